// ----- design/rcsfr_pkg.sv -----
// Package for the serial frame receiver: event codes, frame constants and the
// command and status structs that join the controller to the datapath.
// No dependencies.
`default_nettype none

package rcsfr_pkg;

  localparam int CHANNELS = 14;
  localparam int CHAN_W   = 4;
  localparam int POS_W    = 5;
  localparam int WORD_AW  = 4;
  localparam int WORDS    = 16;

  localparam logic [7:0]  HDR_FIRST    = 8'h20;
  localparam logic [7:0]  HDR_SECOND   = 8'h40;
  localparam logic [15:0] SUM_INIT     = 16'hFFFF;
  localparam logic [POS_W-1:0] POS_TRAILER_LO = 5'd30;
  localparam logic [POS_W-1:0] POS_LAST       = 5'd31;
  localparam logic [CHAN_W-1:0] LAST_CHAN     = CHAN_W'(CHANNELS - 1);

  localparam logic [1:0] EV_NONE    = 2'd0;
  localparam logic [1:0] EV_VALID   = 2'd1;
  localparam logic [1:0] EV_BAD_HDR = 2'd2;
  localparam logic [1:0] EV_BAD_CKS = 2'd3;

  typedef struct packed {
    logic                accept;
    logic                chan_mode;
    logic [CHAN_W-1:0]   chan;
    logic [WORD_AW-1:0]  rd_addr;
  } ctl_cmd_t;

  typedef struct packed {
    logic good_frame;
  } dp_stat_t;

endpackage

`default_nettype wire

// ----- design/rc_serial_frame_receiver_top.sv -----
// Serial frame receiver: one input word per accept, results from the next cycle on.
// Latency: the first result is valid the cycle after the input word is taken.
// A tick or ordinary byte gives a single result; a good frame's last byte gives
// the 14 channel results, read one by one from the frame store port.
// A new input word is taken only once all results of the previous one are gone.
// Reset: synchronous rst clears counters, frame state and sets the timeout to 100.
`default_nettype none

module rc_serial_frame_receiver_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        command,
  input  wire logic [7:0]  rx_byte,
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_wdata,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       event_res,
  output logic [3:0]       channel_index,
  output logic [15:0]      channel_value,
  output logic             last,
  output logic             link_valid,
  output logic [31:0]      bytes_count,
  output logic [31:0]      frames_count,
  output logic [31:0]      good_frames,
  output logic [31:0]      header_errors,
  output logic [31:0]      checksum_errors
);

  rcsfr_pkg::ctl_cmd_t cmd;
  rcsfr_pkg::dp_stat_t stat;

  rcsfr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  rcsfr_dpath u_dpath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .stat            (stat),
    .command         (command),
    .rx_byte         (rx_byte),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .event_res       (event_res),
    .channel_index   (channel_index),
    .channel_value   (channel_value),
    .last            (last),
    .link_valid      (link_valid),
    .bytes_count     (bytes_count),
    .frames_count    (frames_count),
    .good_frames     (good_frames),
    .header_errors   (header_errors),
    .checksum_errors (checksum_errors)
  );

endmodule

`default_nettype wire

// ----- design/rcsfr_ram.sv -----
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
`default_nettype none

module rcsfr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

// ----- design/rcsfr_ctrl.sv -----
// Controller of the serial frame receiver: accepts words, then presents one
// result or walks the channel results of a good frame. Uses rcsfr_pkg.
`default_nettype none

module rcsfr_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  output logic                   out_valid,
  input  wire logic              out_stall,
  input  wire rcsfr_pkg::dp_stat_t stat,
  output rcsfr_pkg::ctl_cmd_t    cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_HOLD = 2'd1;
  localparam logic [1:0] ST_CHAN = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic [rcsfr_pkg::CHAN_W-1:0] chan;
  logic [rcsfr_pkg::CHAN_W-1:0] chan_next;
  logic accept;
  logic take;

  assign accept = (state == ST_IDLE) && in_valid;
  assign take   = !out_stall;

  always_comb begin
    state_next = state;
    chan_next  = chan;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = stat.good_frame ? ST_CHAN : ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (take) begin
          state_next = ST_IDLE;
        end
      end
      ST_CHAN: begin
        if (take) begin
          if (chan == rcsfr_pkg::LAST_CHAN) begin
            state_next = ST_IDLE;
            chan_next  = '0;
          end else begin
            chan_next = chan + 4'd1;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
        chan_next  = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      chan  <= '0;
    end else begin
      state <= state_next;
      chan  <= chan_next;
    end
  end

  assign in_stall  = (state != ST_IDLE);
  assign out_valid = (state == ST_HOLD) || (state == ST_CHAN);

  // Channel i sits in word i + 1. Reading one word ahead when a result is
  // taken keeps the channel results on consecutive cycles.
  always_comb begin
    cmd.accept    = accept;
    cmd.chan_mode = (state == ST_CHAN);
    cmd.chan      = chan;
    if ((state == ST_CHAN) && take) begin
      cmd.rd_addr = chan + 4'd2;
    end else begin
      cmd.rd_addr = chan + 4'd1;
    end
  end

endmodule

`default_nettype wire

// ----- design/rcsfr_dpath.sv -----
// Datapath of the serial frame receiver: frame position, checksum, counters,
// frame age, the timeout register and the frame store. Uses rcsfr_pkg, rcsfr_ram.
`default_nettype none

module rcsfr_dpath (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire rcsfr_pkg::ctl_cmd_t cmd,
  output rcsfr_pkg::dp_stat_t      stat,
  input  wire logic                command,
  input  wire logic [7:0]          rx_byte,
  input  wire logic                cfg_we,
  input  wire logic [15:0]         cfg_wdata,
  output logic [1:0]               event_res,
  output logic [3:0]               channel_index,
  output logic [15:0]              channel_value,
  output logic                     last,
  output logic                     link_valid,
  output logic [31:0]              bytes_count,
  output logic [31:0]              frames_count,
  output logic [31:0]              good_frames,
  output logic [31:0]              header_errors,
  output logic [31:0]              checksum_errors
);

  logic [15:0] stale_timeout;
  logic [rcsfr_pkg::POS_W-1:0] position;
  logic [rcsfr_pkg::POS_W-1:0] position_next;
  logic [15:0] running_sum;
  logic [15:0] running_sum_next;
  logic [7:0]  low_byte;
  logic [7:0]  low_byte_next;
  logic [31:0] byte_counter;
  logic [31:0] byte_counter_next;
  logic [31:0] frame_counter;
  logic [31:0] frame_counter_next;
  logic [31:0] valid_counter;
  logic [31:0] valid_counter_next;
  logic [31:0] header_counter;
  logic [31:0] header_counter_next;
  logic [31:0] checksum_counter;
  logic [31:0] checksum_counter_next;
  logic [31:0] frame_age;
  logic [31:0] frame_age_next;
  logic        seen_frame;
  logic        seen_frame_next;
  logic [1:0]  event_reg;
  logic [1:0]  event_next;
  logic        good;
  logic        wr_en;
  logic [15:0] wr_word;
  logic [15:0] rd_word;

  always_comb begin
    position_next         = position;
    running_sum_next      = running_sum;
    low_byte_next         = low_byte;
    byte_counter_next     = byte_counter;
    frame_counter_next    = frame_counter;
    valid_counter_next    = valid_counter;
    header_counter_next   = header_counter;
    checksum_counter_next = checksum_counter;
    frame_age_next        = frame_age;
    seen_frame_next       = seen_frame;
    event_next            = rcsfr_pkg::EV_NONE;
    good                  = 1'b0;
    wr_en                 = 1'b0;
    wr_word               = {rx_byte, low_byte};

    if (command) begin
      if (frame_age != 32'hFFFF_FFFF) begin
        frame_age_next = frame_age + 32'd1;
      end
    end else begin
      byte_counter_next = byte_counter + 32'd1;
      if (position == '0) begin
        if (rx_byte == rcsfr_pkg::HDR_FIRST) begin
          position_next    = 5'd1;
          running_sum_next = rcsfr_pkg::SUM_INIT - {8'd0, rcsfr_pkg::HDR_FIRST};
          low_byte_next    = rcsfr_pkg::HDR_FIRST;
        end
      end else if ((position == 5'd1) && (rx_byte != rcsfr_pkg::HDR_SECOND)) begin
        header_counter_next = header_counter + 32'd1;
        event_next          = rcsfr_pkg::EV_BAD_HDR;
        if (rx_byte == rcsfr_pkg::HDR_FIRST) begin
          position_next    = 5'd1;
          running_sum_next = rcsfr_pkg::SUM_INIT - {8'd0, rcsfr_pkg::HDR_FIRST};
          low_byte_next    = rcsfr_pkg::HDR_FIRST;
        end else begin
          position_next    = '0;
          running_sum_next = rcsfr_pkg::SUM_INIT;
        end
      end else begin
        // Bytes are stored in pairs: the even byte waits in low_byte and is
        // written together with the odd byte that follows it.
        if (!position[0]) begin
          low_byte_next = rx_byte;
        end else begin
          wr_en = 1'b1;
        end
        if (position < rcsfr_pkg::POS_TRAILER_LO) begin
          running_sum_next = running_sum - {8'd0, rx_byte};
        end
        if (position == rcsfr_pkg::POS_LAST) begin
          position_next      = '0;
          running_sum_next   = rcsfr_pkg::SUM_INIT;
          frame_counter_next = frame_counter + 32'd1;
          if (wr_word != running_sum) begin
            checksum_counter_next = checksum_counter + 32'd1;
            event_next            = rcsfr_pkg::EV_BAD_CKS;
          end else begin
            good                = 1'b1;
            valid_counter_next  = valid_counter + 32'd1;
            frame_age_next      = '0;
            seen_frame_next     = 1'b1;
            event_next          = rcsfr_pkg::EV_VALID;
          end
        end else begin
          position_next = position + 5'd1;
        end
      end
    end
  end

  assign stat.good_frame = good;

  always_ff @(posedge clk) begin
    if (rst) begin
      stale_timeout    <= 16'd100;
      position         <= '0;
      running_sum      <= rcsfr_pkg::SUM_INIT;
      byte_counter     <= '0;
      frame_counter    <= '0;
      valid_counter    <= '0;
      header_counter   <= '0;
      checksum_counter <= '0;
      frame_age        <= '0;
      seen_frame       <= 1'b0;
    end else begin
      if (cfg_we) begin
        stale_timeout <= cfg_wdata;
      end
      if (cmd.accept) begin
        position         <= position_next;
        running_sum      <= running_sum_next;
        byte_counter     <= byte_counter_next;
        frame_counter    <= frame_counter_next;
        valid_counter    <= valid_counter_next;
        header_counter   <= header_counter_next;
        checksum_counter <= checksum_counter_next;
        frame_age        <= frame_age_next;
        seen_frame       <= seen_frame_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      low_byte  <= low_byte_next;
      event_reg <= event_next;
    end
  end

  rcsfr_ram #(
    .WIDTH(16),
    .DEPTH(rcsfr_pkg::WORDS)
  ) u_store (
    .clk     (clk),
    .wr_en   (cmd.accept && wr_en),
    .wr_addr (position[rcsfr_pkg::POS_W-1:1]),
    .wr_data (wr_word),
    .rd_addr (cmd.rd_addr),
    .rd_data (rd_word)
  );

  assign event_res     = cmd.chan_mode ? rcsfr_pkg::EV_VALID : event_reg;
  assign channel_index = cmd.chan_mode ? cmd.chan : 4'd0;
  assign channel_value = cmd.chan_mode ? rd_word : 16'd0;
  assign last          = cmd.chan_mode ? (cmd.chan == rcsfr_pkg::LAST_CHAN) : 1'b1;

  assign link_valid      = seen_frame && (frame_age <= {16'd0, stale_timeout});
  assign bytes_count     = byte_counter;
  assign frames_count    = frame_counter;
  assign good_frames     = valid_counter;
  assign header_errors   = header_counter;
  assign checksum_errors = checksum_counter;

endmodule

`default_nettype wire

// ----- design/rcsfr_checker.sv -----
// Port-level checks for the serial frame receiver, bound to the top level.
// Uses rcsfr_pkg.
`default_nettype none

module rcsfr_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [1:0]  event_res,
  input wire logic [3:0]  channel_index,
  input wire logic [15:0] channel_value,
  input wire logic        last,
  input wire logic [31:0] bytes_count,
  input wire logic [31:0] frames_count,
  input wire logic [31:0] good_frames,
  input wire logic [31:0] checksum_errors
);

  // Every checked frame is either good or a checksum failure.
  a_frame_split: assert property (@(posedge clk) disable iff (rst)
    32'(good_frames + checksum_errors) == frames_count)
    else $error("frame counters disagree");

  // No new input word is taken while a result is pending.
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("input taken while result pending");

  // Channel results of a good frame follow one another in order.
  a_chan_order: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && (event_res == rcsfr_pkg::EV_VALID) && !last |=>
      out_valid && (event_res == rcsfr_pkg::EV_VALID) &&
      (channel_index == 4'($past(channel_index) + 4'd1)))
    else $error("channel sequence broken");

  // Error results stand alone.
  a_err_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && ((event_res == rcsfr_pkg::EV_BAD_HDR) ||
                  (event_res == rcsfr_pkg::EV_BAD_CKS)) |-> last)
    else $error("error result not marked last");

  // A stalled result holds its byte count, event code and channel value.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(bytes_count) && $stable(event_res) &&
      $stable(channel_value))
    else $error("stalled result changed");

endmodule

bind rc_serial_frame_receiver_top rcsfr_checker u_rcsfr_checker (.*);

`default_nettype wire

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for rc_serial_frame_receiver_top: byte and tick words in, per-word
// results out, each checked against a predictor of the frame receiver kept in this file.
// Depends on rcsfr_pkg and the design top only.

module testbench;

  localparam int FRAME_BYTES = 32;

  typedef struct packed {
    logic [1:0]  ev;
    logic [3:0]  idx;
    logic [15:0] val;
    logic        lst;
    logic        sig;
    logic [31:0] n_bytes;
    logic [31:0] n_frames;
    logic [31:0] n_good;
    logic [31:0] n_hdr;
    logic [31:0] n_cks;
  } rx_result_t;

  typedef struct packed {
    logic       cmd;
    logic [7:0] data;
    logic [1:0] ev;
  } hunt_row_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic        command;
  logic [7:0]  rx_byte;
  logic        cfg_we;
  logic [15:0] cfg_wdata;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  event_res;
  logic [3:0]  channel_index;
  logic [15:0] channel_value;
  logic        last;
  logic        link_valid;
  logic [31:0] bytes_count;
  logic [31:0] frames_count;
  logic [31:0] good_frames;
  logic [31:0] header_errors;
  logic [31:0] checksum_errors;

  rc_serial_frame_receiver_top uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .command(command), .rx_byte(rx_byte),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .out_valid(out_valid), .out_stall(out_stall),
    .event_res(event_res), .channel_index(channel_index),
    .channel_value(channel_value), .last(last), .link_valid(link_valid),
    .bytes_count(bytes_count), .frames_count(frames_count),
    .good_frames(good_frames), .header_errors(header_errors),
    .checksum_errors(checksum_errors)
  );

  // Predicted receiver state.
  logic [5:0]  hunt_pos;
  logic [7:0]  frame_buf [FRAME_BYTES];
  logic [15:0] csum;
  logic [31:0] cnt_bytes, cnt_frames, cnt_good, cnt_hdr, cnt_cks;
  logic [31:0] age_ms;
  logic        have_frame;
  logic [15:0] timeout_ms;

  rx_result_t pending_results [$];
  bit         row_typed;
  logic [1:0] row_ev;
  bit         quiet;
  bit         hold_req;
  int         fail_count;
  int         words_sent;
  int         results_seen;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic void push_result(logic [1:0] ev, logic [3:0] idx, logic [15:0] val,
                                      logic lst);
    rx_result_t r;
    r.ev       = row_typed ? row_ev : ev;
    r.idx      = idx;
    r.val      = val;
    r.lst      = lst;
    r.sig      = have_frame && (age_ms <= {16'd0, timeout_ms});
    r.n_bytes  = cnt_bytes;
    r.n_frames = cnt_frames;
    r.n_good   = cnt_good;
    r.n_hdr    = cnt_hdr;
    r.n_cks    = cnt_cks;
    pending_results.push_back(r);
  endfunction

  function automatic void open_frame();
    frame_buf[0] = rcsfr_pkg::HDR_FIRST;
    csum         = rcsfr_pkg::SUM_INIT - 16'(rcsfr_pkg::HDR_FIRST);
    hunt_pos     = 6'd1;
  endfunction

  // Works out every result that one accepted word produces.
  function automatic void decode_word(logic cmd, logic [7:0] b, bit typed, logic [1:0] ev);
    logic [4:0]  p;
    logic [15:0] trailer;
    row_typed = typed;
    row_ev    = ev;
    if (cmd) begin
      if (age_ms != 32'hFFFF_FFFF) age_ms++;
      push_result(rcsfr_pkg::EV_NONE, 4'd0, 16'd0, 1'b1);
    end else begin
      cnt_bytes++;
      if (hunt_pos == 6'd0) begin
        if (b == rcsfr_pkg::HDR_FIRST) open_frame();
        push_result(rcsfr_pkg::EV_NONE, 4'd0, 16'd0, 1'b1);
      end else if (hunt_pos == 6'd1 && b != rcsfr_pkg::HDR_SECOND) begin
        cnt_hdr++;
        if (b == rcsfr_pkg::HDR_FIRST) begin
          open_frame();
        end else begin
          hunt_pos = 6'd0;
          csum     = rcsfr_pkg::SUM_INIT;
        end
        push_result(rcsfr_pkg::EV_BAD_HDR, 4'd0, 16'd0, 1'b1);
      end else begin
        p            = hunt_pos[4:0];
        frame_buf[p] = b;
        if (p < 5'd30) csum = csum - 16'(b);
        hunt_pos = 6'(p) + 6'd1;
        if (hunt_pos < 6'(FRAME_BYTES)) begin
          push_result(rcsfr_pkg::EV_NONE, 4'd0, 16'd0, 1'b1);
        end else begin
          trailer  = {frame_buf[31], frame_buf[30]};
          hunt_pos = 6'd0;
          cnt_frames++;
          if (trailer != csum) begin
            cnt_cks++;
            push_result(rcsfr_pkg::EV_BAD_CKS, 4'd0, 16'd0, 1'b1);
          end else begin
            cnt_good++;
            age_ms     = 32'd0;
            have_frame = 1'b1;
            for (int i = 0; i < rcsfr_pkg::CHANNELS; i++)
              push_result(rcsfr_pkg::EV_VALID, 4'(i), {frame_buf[2*i+3], frame_buf[2*i+2]},
                          i == rcsfr_pkg::CHANNELS - 1);
          end
          csum = rcsfr_pkg::SUM_INIT;
        end
      end
    end
  endfunction

  function automatic int sender_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 30);
  endfunction

  task automatic send_word(input logic cmd, input logic [7:0] b, input bit typed,
                           input logic [1:0] ev);
    int gap;
    gap = sender_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    command  <= cmd;
    rx_byte  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    decode_word(cmd, b, typed, ev);
    words_sent++;
  endtask

  task automatic send_byte(input logic [7:0] b);
    send_word(1'b0, b, 1'b0, rcsfr_pkg::EV_NONE);
  endtask

  task automatic send_tick();
    send_word(1'b1, 8'($urandom_range(0, 255)), 1'b0, rcsfr_pkg::EV_NONE);
  endtask

  // A full frame; fill < 0 gives random channel data, else every channel takes fill.
  task automatic send_frame(input bit good, input int fill, input bit mix_ticks);
    logic [7:0]  fb [FRAME_BYTES];
    logic [15:0] sum;
    logic [15:0] chan;
    fb[0] = rcsfr_pkg::HDR_FIRST;
    fb[1] = rcsfr_pkg::HDR_SECOND;
    sum   = rcsfr_pkg::SUM_INIT - 16'(rcsfr_pkg::HDR_FIRST) - 16'(rcsfr_pkg::HDR_SECOND);
    for (int i = 0; i < rcsfr_pkg::CHANNELS; i++) begin
      if (fill >= 0) chan = 16'(fill);
      else if ($urandom_range(0, 7) == 0) chan = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      else chan = 16'($urandom_range(0, 65535));
      fb[2*i+2] = chan[7:0];
      fb[2*i+3] = chan[15:8];
      sum = sum - 16'(chan[7:0]) - 16'(chan[15:8]);
    end
    if (!good) sum = sum ^ 16'($urandom_range(1, 65535));
    fb[30] = sum[7:0];
    fb[31] = sum[15:8];
    for (int i = 0; i < FRAME_BYTES; i++) begin
      if (mix_ticks && $urandom_range(0, 9) == 0) send_tick();
      send_byte(fb[i]);
    end
  endtask

  task automatic random_sequence(input bit force_good);
    int r;
    logic [7:0] b;
    r = force_good ? 0 : $urandom_range(0, 99);
    if (r < 50) begin
      send_frame(1'b1, -1, r >= 35);
    end else if (r < 65) begin
      send_frame(1'b0, -1, 1'b0);
    end else if (r < 75) begin
      send_byte(rcsfr_pkg::HDR_FIRST);
      if ($urandom_range(0, 3) == 0) begin
        b = rcsfr_pkg::HDR_FIRST;
      end else begin
        b = 8'($urandom_range(0, 255));
        if (b == rcsfr_pkg::HDR_SECOND) b = ~b;
      end
      send_byte(b);
    end else if (r < 88) begin
      repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
    end else begin
      repeat ($urandom_range(1, 4)) send_tick();
    end
  endtask

  task automatic idle_and_drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic set_timeout(input logic [15:0] v);
    idle_and_drain();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we     <= 1'b0;
    timeout_ms  = v;
  endtask

  // Receiver side: random stalls, plus one long hold-off on request.
  initial begin : receiver_stall
    int hold_left;
    int run_left;
    int r;
    bit stall_now;
    hold_left = 0;
    run_left  = 0;
    stall_now = 1'b0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_left = 300;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        stall_now = 1'b1;
      end else if (quiet) begin
        stall_now = 1'b0;
      end else if (run_left > 0) begin
        run_left--;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 60) begin
          stall_now = 1'b0;
          run_left  = $urandom_range(0, 8);
        end else if (r < 90) begin
          stall_now = 1'b1;
          run_left  = $urandom_range(0, 2);
        end else begin
          stall_now = 1'b1;
          run_left  = $urandom_range(10, 40);
        end
      end
      out_stall <= stall_now;
    end
  end

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin : result_check
    rx_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result word with no expectation pending (event %0d)", event_res);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        results_seen++;
        check_field("event_res", 32'(want.ev), 32'(event_res));
        check_field("channel_index", 32'(want.idx), 32'(channel_index));
        check_field("channel_value", 32'(want.val), 32'(channel_value));
        check_field("last", 32'(want.lst), 32'(last));
        check_field("link_valid", 32'(want.sig), 32'(link_valid));
        check_field("bytes_count", want.n_bytes, bytes_count);
        check_field("frames_count", want.n_frames, frames_count);
        check_field("good_frames", want.n_good, good_frames);
        check_field("header_errors", want.n_hdr, header_errors);
        check_field("checksum_errors", want.n_cks, checksum_errors);
      end
    end
  end

  initial begin
    #8_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin : stimulus
    hunt_row_t   hunt_rows [13];
    logic [15:0] phase_timeouts [4];
    int          phase_ends [4];

    // Header hunting cases; every row's event code is obvious from the frame rules.
    hunt_rows = '{
      {1'b1, 8'h00,                 rcsfr_pkg::EV_NONE},     // tick straight after reset
      {1'b0, 8'h00,                 rcsfr_pkg::EV_NONE},
      {1'b0, 8'hFF,                 rcsfr_pkg::EV_NONE},
      {1'b0, rcsfr_pkg::HDR_SECOND, rcsfr_pkg::EV_NONE},     // stray second byte while hunting
      {1'b0, rcsfr_pkg::HDR_FIRST,  rcsfr_pkg::EV_NONE},
      {1'b0, rcsfr_pkg::HDR_FIRST,  rcsfr_pkg::EV_BAD_HDR},  // repeated first byte resyncs
      {1'b0, 8'h00,                 rcsfr_pkg::EV_BAD_HDR},  // wrong second byte, back to hunt
      {1'b0, rcsfr_pkg::HDR_FIRST,  rcsfr_pkg::EV_NONE},
      {1'b0, 8'hFF,                 rcsfr_pkg::EV_BAD_HDR},
      {1'b0, rcsfr_pkg::HDR_FIRST,  rcsfr_pkg::EV_NONE},
      {1'b1, 8'hFF,                 rcsfr_pkg::EV_NONE},     // tick leaves the hunt alone
      {1'b0, rcsfr_pkg::HDR_FIRST,  rcsfr_pkg::EV_BAD_HDR},
      {1'b0, 8'h7F,                 rcsfr_pkg::EV_BAD_HDR}
    };

    rst        = 1'b1;
    in_valid   = 1'b0;
    command    = 1'b0;
    rx_byte    = 8'h00;
    cfg_we     = 1'b0;
    cfg_wdata  = 16'h0000;
    quiet      = 1'b0;
    hold_req   = 1'b0;
    fail_count = 0;
    words_sent = 0;
    results_seen = 0;
    hunt_pos   = 6'd0;
    csum       = rcsfr_pkg::SUM_INIT;
    cnt_bytes  = 32'd0;
    cnt_frames = 32'd0;
    cnt_good   = 32'd0;
    cnt_hdr    = 32'd0;
    cnt_cks    = 32'd0;
    age_ms     = 32'd0;
    have_frame = 1'b0;
    timeout_ms = 16'd100;
    for (int i = 0; i < FRAME_BYTES; i++) frame_buf[i] = 8'h00;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (hunt_rows[i])
      send_word(hunt_rows[i].cmd, hunt_rows[i].data, 1'b1, hunt_rows[i].ev);

    // All-ones channel values, then a checksum failure, at the reset timeout.
    send_frame(1'b1, 16'hFFFF, 1'b0);
    send_frame(1'b0, -1, 1'b0);

    phase_timeouts[0] = 16'd0;
    phase_timeouts[1] = 16'd1;
    phase_timeouts[2] = 16'hFFFF;
    phase_timeouts[3] = 16'($urandom_range(2, 6));
    phase_ends[0] = 84;
    phase_ends[1] = 90;
    phase_ends[2] = 96;
    phase_ends[3] = 104;
    for (int p = 0; p < 4; p++) begin
      set_timeout(phase_timeouts[p]);
      quiet = (p == 1);
      // The long hold-off lets results back up until the input side stalls.
      if (p == 2) begin
        hold_req = 1'b1;
        repeat (3) send_tick();
      end
      do random_sequence(1'b0); while (words_sent < phase_ends[p]);
    end
    quiet = 1'b0;

    idle_and_drain();
    repeat (20) @(posedge clk);

    $display("Sent %0d words (%0d bytes) and checked %0d result words.",
             words_sent, cnt_bytes, results_seen);
    $display("Saw %0d good frames, %0d checksum failures, %0d header errors;",
             cnt_good, cnt_cks, cnt_hdr);
    $display("timeouts ran from 0 to 65535, with one long output hold-off.");
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
